@@ src/dersig_pkg.sv @@
package dersig_pkg;

  localparam int unsigned MAX_SIG_BYTES = 72;
  localparam int unsigned MIN_SIG_BYTES = 8;
  localparam int unsigned MAX_INT_BYTES = 33;

  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;
  localparam logic [7:0] SIGN_BIT     = 8'h80;

  // secp256k1 group order and (order-1)/2, most significant byte first
  localparam logic [255:0] ORDER_G =
    256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;
  localparam logic [255:0] HALF_G =
    256'h7FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF5D576E7357A4501DDFE92F46681B20A0;

  typedef enum logic [1:0] {
    VERDICT_INVALID   = 2'd0,
    VERDICT_CANONICAL = 2'd1,
    VERDICT_FULL      = 2'd2
  } verdict_t;

  // one accepted input word
  typedef struct packed {
    logic [7:0] sig_byte;
    logic       final_byte;
  } dersig_word_t;

  // handshake between input stage and parser
  typedef struct packed {
    logic         valid;
    dersig_word_t word;
  } dersig_fwd_t;

  // byte idx (0..32) of a 256-bit constant viewed as 33 bytes with a zero top byte
  function automatic logic [7:0] const_byte(input logic [255:0] k, input logic [5:0] idx);
    logic [4:0] pos;
    logic [7:0] res;
    pos = 5'(6'd32 - idx);
    res = 8'h00;
    if (idx != 6'd0 && idx <= 6'd32) begin
      res = k[{pos, 3'b000} +: 8];
    end
    return res;
  endfunction

endpackage

@@ src/dersig_in_stage.sv @@
module dersig_in_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,
  input  logic                    in_tlast,
  input  logic                    take,
  output dersig_pkg::dersig_fwd_t fwd
);
  import dersig_pkg::*;

  logic         valid_r;
  logic         valid_nxt;
  dersig_word_t word_r;

  assign in_tready = !valid_r || take;
  assign valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      word_r.sig_byte   <= in_tdata;
      word_r.final_byte <= in_tlast;
    end
  end

  assign fwd.valid = valid_r;
  assign fwd.word  = word_r;

endmodule

@@ src/dersig_parse.sv @@
module dersig_parse (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dersig_pkg::dersig_fwd_t fwd,
  input  logic                    out_free,
  output logic                    take,
  output logic                    res_valid,
  output dersig_pkg::verdict_t    res_verdict
);
  import dersig_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_LEN  = 3'd1,
    PH_RTAG = 3'd2,
    PH_RLEN = 3'd3,
    PH_RVAL = 3'd4,
    PH_STAG = 3'd5,
    PH_SLEN = 3'd6,
    PH_SVAL = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_LT = 2'd1,
    CMP_GT = 2'd2
  } cmp_t;

  phase_t     phase_r, phase_nxt;
  logic [6:0] pos_r, pos_nxt;
  logic [7:0] decl_r, decl_nxt;
  logic [5:0] plen_r, plen_nxt;
  logic [5:0] left_r, left_nxt;
  logic [7:0] lead_r, lead_nxt;
  cmp_t       rcmp_r, rcmp_nxt;
  cmp_t       scmp_r, scmp_nxt;
  cmp_t       hcmp_r, hcmp_nxt;
  logic       err_r, err_nxt;

  logic [7:0] b;
  logic [5:0] k;
  logic [5:0] idx;
  logic [7:0] og_byte;
  logic [7:0] hg_byte;
  logic       ok;
  logic [8:0] decl_plus2;

  assign take = fwd.valid && (!fwd.word.final_byte || out_free);
  assign b    = fwd.word.sig_byte;
  assign k    = plen_r - left_r;
  assign idx  = 6'(6'd33 - plen_r + k);
  assign og_byte = const_byte(ORDER_G, idx);
  assign hg_byte = const_byte(HALF_G, idx);

  function automatic cmp_t cmp_step(input cmp_t st, input logic [7:0] v, input logic [7:0] c);
    cmp_t res;
    res = st;
    if (st == CMP_EQ) begin
      if (v < c) res = CMP_LT;
      else if (v > c) res = CMP_GT;
    end
    return res;
  endfunction

  // one byte through the DER parser
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    decl_nxt  = decl_r;
    plen_nxt  = plen_r;
    left_nxt  = left_r;
    lead_nxt  = lead_r;
    rcmp_nxt  = rcmp_r;
    scmp_nxt  = scmp_r;
    hcmp_nxt  = hcmp_r;
    err_nxt   = err_r;

    if (pos_r <= 7'(MAX_SIG_BYTES)) begin
      pos_nxt = pos_r + 7'd1;
    end
    if (pos_nxt > 7'(MAX_SIG_BYTES)) begin
      err_nxt = 1'b1;
    end

    if (!err_nxt) begin
      case (phase_r)
        PH_HDR: begin
          if (b != TAG_SEQUENCE) err_nxt = 1'b1;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          decl_nxt  = b;
          phase_nxt = PH_RTAG;
        end
        PH_RTAG, PH_STAG: begin
          if (b != TAG_INTEGER) err_nxt = 1'b1;
          phase_nxt = (phase_r == PH_RTAG) ? PH_RLEN : PH_SLEN;
        end
        PH_RLEN, PH_SLEN: begin
          if (b < 8'd1 || b > 8'(MAX_INT_BYTES)) begin
            err_nxt = 1'b1;
          end else begin
            plen_nxt = b[5:0];
            left_nxt = b[5:0];
            if (phase_r == PH_RLEN) begin
              rcmp_nxt = (b == 8'(MAX_INT_BYTES)) ? CMP_EQ : CMP_LT;
            end else begin
              scmp_nxt = (b == 8'(MAX_INT_BYTES)) ? CMP_EQ : CMP_LT;
              hcmp_nxt = (b == 8'(MAX_INT_BYTES)) ? CMP_EQ : CMP_LT;
            end
          end
          phase_nxt = (phase_r == PH_RLEN) ? PH_RVAL : PH_SVAL;
        end
        PH_RVAL, PH_SVAL: begin
          if (phase_r == PH_SVAL && left_r == 6'd0) begin
            // trailing byte after the second integer
            err_nxt = 1'b1;
          end else begin
            if (k == 6'd0) begin
              if ((b & SIGN_BIT) != 8'h00) err_nxt = 1'b1;
              if (b == 8'h00 && plen_r == 6'd1) err_nxt = 1'b1;
              lead_nxt = b;
            end else if (k == 6'd1) begin
              // padding byte only allowed before a set sign bit
              if (lead_r == 8'h00 && (b & SIGN_BIT) == 8'h00) err_nxt = 1'b1;
            end
            if (phase_r == PH_SVAL) begin
              scmp_nxt = cmp_step(scmp_r, b, og_byte);
              hcmp_nxt = cmp_step(hcmp_r, b, hg_byte);
            end else begin
              rcmp_nxt = cmp_step(rcmp_r, b, og_byte);
            end
            left_nxt = left_r - 6'd1;
            if (phase_r == PH_RVAL && left_nxt == 6'd0) begin
              phase_nxt = PH_STAG;
            end
          end
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end
  end

  assign decl_plus2 = {1'b0, decl_nxt} + 9'd2;

  always_comb begin
    ok = !err_nxt
      && pos_nxt >= 7'(MIN_SIG_BYTES)
      && pos_nxt <= 7'(MAX_SIG_BYTES)
      && decl_plus2 == {2'b00, pos_nxt}
      && phase_nxt == PH_SVAL
      && left_nxt == 6'd0
      && rcmp_nxt == CMP_LT
      && scmp_nxt == CMP_LT;
    if (!ok) begin
      res_verdict = VERDICT_INVALID;
    end else if (hcmp_nxt == CMP_GT) begin
      res_verdict = VERDICT_CANONICAL;
    end else begin
      res_verdict = VERDICT_FULL;
    end
  end

  assign res_valid = take && fwd.word.final_byte;

  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      phase_r <= PH_HDR;
      pos_r   <= 7'd0;
      decl_r  <= 8'd0;
      plen_r  <= 6'd0;
      left_r  <= 6'd0;
      lead_r  <= 8'd0;
      rcmp_r  <= CMP_EQ;
      scmp_r  <= CMP_EQ;
      hcmp_r  <= CMP_EQ;
      err_r   <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      decl_r  <= decl_nxt;
      plen_r  <= plen_nxt;
      left_r  <= left_nxt;
      lead_r  <= lead_nxt;
      rcmp_r  <= rcmp_nxt;
      scmp_r  <= scmp_nxt;
      hcmp_r  <= hcmp_nxt;
      err_r   <= err_nxt;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (phase_r == PH_HDR && pos_r == 7'd0 && !err_r))
    else $error("parser did not restart after a verdict");

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 7'(MAX_SIG_BYTES + 1))
    else $error("byte counter past saturation");

  a_overlong_err: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r > 7'(MAX_SIG_BYTES)) |-> err_r)
    else $error("overlong signature without error flag");

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= plen_r)
    else $error("value bytes left exceed integer length");

endmodule

@@ src/der_ecdsa_signature_canonicality_top.sv @@
// a verdict word is registered on out_* when the parser takes the final byte from the input register
// throughput: one signature byte per cycle, sustained while no verdict is stalled, set by the single-pass byte parser
// a final byte waits in the input register only while a previous verdict is still stalled
// reset: synchronous active-low rst_n; empties both registers and returns the parser
// to the sequence header with all counters and compare states cleared
module der_ecdsa_signature_canonicality_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] sig_byte
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] verdict, [7:2] zero
);
  import dersig_pkg::*;

  dersig_fwd_t fwd;
  logic        take;
  logic        out_free;
  logic        res_valid;
  verdict_t    res_verdict;

  logic        out_valid_r;
  logic        out_valid_nxt;
  verdict_t    verdict_r;

  // input register: decouples the byte stream from the parser
  dersig_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .take      (take),
    .fwd       (fwd)
  );

  // parser state and per-byte checks; a verdict comes out with the final byte
  dersig_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .fwd         (fwd),
    .out_free    (out_free),
    .take        (take),
    .res_valid   (res_valid),
    .res_verdict (res_verdict)
  );

  // result register: free when empty or being drained this cycle
  assign out_free      = !out_valid_r || out_tready;
  assign out_valid_nxt = res_valid ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      verdict_r <= res_verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, verdict_r};

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !res_valid)
    else $error("verdict overwritten while stalled");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (verdict_r == VERDICT_INVALID || verdict_r == VERDICT_CANONICAL
                     || verdict_r == VERDICT_FULL))
    else $error("verdict code out of range");

  a_final_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (fwd.valid && fwd.word.final_byte && !out_free) |-> !take)
    else $error("final byte consumed without room for its verdict");

endmodule

@@ sim/der_ecdsa_signature_canonicality_top_tb.sv @@
`timescale 1ns / 1ps

module der_ecdsa_signature_canonicality_top_tb;
  import dersig_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AT = 150;      // accepted bytes before the long output hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int CALM_FROM = 300;    // window of accepted bytes with no idling
  localparam int CALM_TO = 450;

  // parser phases of the predictor
  typedef enum logic [2:0] {
    EXP_SEQ_TAG, EXP_SEQ_LEN, EXP_R_TAG, EXP_R_LEN,
    EXP_R_VAL, EXP_S_TAG, EXP_S_LEN, EXP_S_VAL
  } der_phase_t;

  // running magnitude compare against a constant
  typedef enum logic [1:0] {
    MAG_EQ = 2'd0,
    MAG_LT = 2'd1,
    MAG_GT = 2'd2
  } mag_cmp_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] sig_byte
  logic       in_tlast = 1'b0;    // final_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [1:0] verdict, [7:2] zero

  der_ecdsa_signature_canonicality_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // byte words waiting to be driven, verdicts waiting to arrive
  dersig_word_t pending_bytes[$];
  verdict_t     verdict_q[$];

  // scratch buffers for building signatures
  logic [7:0] int_buf[$];
  logic [7:0] r_val[$];
  logic [7:0] s_val[$];
  logic [7:0] sig_buf[$];

  dersig_word_t next_word;

  int acc_cnt = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;
  int n_errors = 0;
  int n_sigs_sent = 0;
  int n_invalid = 0;
  int n_canon = 0;
  int n_full = 0;
  int n_in_stalls = 0;
  int n_out_holds = 0;

  logic calm;
  assign calm = (acc_cnt >= CALM_FROM) && (acc_cnt < CALM_TO);

  // ---------------------------------------------------------------
  // predictor state
  // ---------------------------------------------------------------
  der_phase_t p_phase;
  logic [6:0] p_count;      // bytes seen, saturates one past the maximum
  logic [7:0] p_seq_len;    // sequence length byte
  logic [5:0] p_int_len;    // length of the integer being parsed
  logic [5:0] p_int_left;   // value bytes of that integer still to come
  logic [7:0] p_lead;       // first value byte of that integer
  mag_cmp_t   p_r_vs_g;
  mag_cmp_t   p_s_vs_g;
  mag_cmp_t   p_s_vs_half;
  logic       p_bad;

  task automatic clear_predictor();
    p_phase     = EXP_SEQ_TAG;
    p_count     = '0;
    p_seq_len   = '0;
    p_int_len   = '0;
    p_int_left  = '0;
    p_lead      = '0;
    p_r_vs_g    = MAG_EQ;
    p_s_vs_g    = MAG_EQ;
    p_s_vs_half = MAG_EQ;
    p_bad       = 1'b0;
  endtask

  // constant seen as 33 bytes msb first, top byte zero
  function automatic logic [7:0] order_byte(input logic [255:0] k, input logic [5:0] idx);
    if (idx == 6'd0 || idx > 6'd32) return 8'h00;
    return k[(32 - idx) * 8 +: 8];
  endfunction

  // first differing byte decides, later bytes keep the decision
  function automatic mag_cmp_t mag_step(input mag_cmp_t st, input logic [7:0] b,
                                        input logic [7:0] c);
    if (st != MAG_EQ) return st;
    if (b < c) return MAG_LT;
    if (b > c) return MAG_GT;
    return MAG_EQ;
  endfunction

  task automatic take_int_len(input logic [7:0] b, input bit is_s);
    if (b < 8'd1 || b > MAX_INT_BYTES) begin
      p_bad = 1'b1;
    end else begin
      p_int_len  = b[5:0];
      p_int_left = b[5:0];
      // anything shorter than 33 bytes is below the group order and is treated as below the half order too
      if (is_s) begin
        p_s_vs_g    = (b == 8'd33) ? MAG_EQ : MAG_LT;
        p_s_vs_half = (b == 8'd33) ? MAG_EQ : MAG_LT;
      end else begin
        p_r_vs_g = (b == 8'd33) ? MAG_EQ : MAG_LT;
      end
    end
  endtask

  task automatic take_int_val(input logic [7:0] b, input bit is_s);
    logic [5:0] k;
    logic [5:0] idx;
    k   = p_int_len - p_int_left;
    idx = 6'd33 - p_int_len + k;
    if (k == 6'd0) begin
      // negative, or a single zero byte
      if (b[7]) p_bad = 1'b1;
      if (b == 8'h00 && p_int_len == 6'd1) p_bad = 1'b1;
      p_lead = b;
    end else if (k == 6'd1) begin
      // leading zero that was not needed
      if (p_lead == 8'h00 && !b[7]) p_bad = 1'b1;
    end
    if (is_s) begin
      p_s_vs_g    = mag_step(p_s_vs_g, b, order_byte(ORDER_G, idx));
      p_s_vs_half = mag_step(p_s_vs_half, b, order_byte(HALF_G, idx));
    end else begin
      p_r_vs_g = mag_step(p_r_vs_g, b, order_byte(ORDER_G, idx));
    end
    p_int_left = p_int_left - 6'd1;
  endtask

  // one accepted byte word; a final byte queues its verdict
  task automatic predict_word(input logic [7:0] b, input logic last);
    verdict_t v;
    if (p_count <= MAX_SIG_BYTES) p_count = p_count + 7'd1;
    if (p_count > MAX_SIG_BYTES) p_bad = 1'b1;
    if (!p_bad) begin
      case (p_phase)
        EXP_SEQ_TAG: begin
          if (b != TAG_SEQUENCE) p_bad = 1'b1;
          p_phase = EXP_SEQ_LEN;
        end
        EXP_SEQ_LEN: begin
          p_seq_len = b;
          p_phase = EXP_R_TAG;
        end
        EXP_R_TAG: begin
          if (b != TAG_INTEGER) p_bad = 1'b1;
          p_phase = EXP_R_LEN;
        end
        EXP_S_TAG: begin
          if (b != TAG_INTEGER) p_bad = 1'b1;
          p_phase = EXP_S_LEN;
        end
        EXP_R_LEN: begin
          take_int_len(b, 1'b0);
          p_phase = EXP_R_VAL;
        end
        EXP_S_LEN: begin
          take_int_len(b, 1'b1);
          p_phase = EXP_S_VAL;
        end
        EXP_R_VAL: begin
          take_int_val(b, 1'b0);
          if (p_int_left == 6'd0) p_phase = EXP_S_TAG;
        end
        default: begin
          // anything after the s value is trailing garbage
          if (p_int_left == 6'd0) p_bad = 1'b1;
          else take_int_val(b, 1'b1);
        end
      endcase
    end
    if (last) begin
      if (p_bad || p_count < MIN_SIG_BYTES || p_count > MAX_SIG_BYTES ||
          9'(p_seq_len) + 9'd2 != 9'(p_count) || p_phase != EXP_S_VAL ||
          p_int_left != 6'd0 || p_r_vs_g != MAG_LT || p_s_vs_g != MAG_LT) begin
        v = VERDICT_INVALID;
      end else if (p_s_vs_half == MAG_GT) begin
        v = VERDICT_CANONICAL;
      end else begin
        v = VERDICT_FULL;
      end
      verdict_q.push_back(v);
      clear_predictor();
    end
  endtask

  // ---------------------------------------------------------------
  // signature builders
  // ---------------------------------------------------------------

  // minimal positive der integer body of v into int_buf
  task automatic encode_int(input logic [263:0] v);
    int_buf.delete();
    for (int i = 32; i >= 0; i--) int_buf.push_back(v[i * 8 +: 8]);
    while (int_buf.size() > 1 && int_buf[0] == 8'h00 && !int_buf[1][7])
      void'(int_buf.pop_front());
  endtask

  // random integer, often short, sometimes within three of the group order or half order
  task automatic rand_value();
    logic [263:0] v;
    int sel;
    sel = $urandom_range(99);
    v = '0;
    for (int i = 0; i < 8; i++) v = {v[231:0], 32'($urandom())};
    if (sel < 15)
      v = {8'h00, ORDER_G} + 264'($urandom_range(6)) - 264'd3;
    else if (sel < 30)
      v = {8'h00, HALF_G} + 264'($urandom_range(6)) - 264'd3;
    else if (sel < 75)
      v = v & ((264'd1 << $urandom_range(1, 24)) - 264'd1);
    else
      v = v & ((264'd1 << $urandom_range(1, 256)) - 264'd1);
    encode_int(v);
  endtask

  // sequence of two integers from r_val and s_val into sig_buf
  task automatic build_der();
    sig_buf.delete();
    sig_buf.push_back(TAG_SEQUENCE);
    sig_buf.push_back(8'(4 + r_val.size() + s_val.size()));
    sig_buf.push_back(TAG_INTEGER);
    sig_buf.push_back(8'(r_val.size()));
    foreach (r_val[i]) sig_buf.push_back(r_val[i]);
    sig_buf.push_back(TAG_INTEGER);
    sig_buf.push_back(8'(s_val.size()));
    foreach (s_val[i]) sig_buf.push_back(s_val[i]);
  endtask

  task automatic build_pair(input logic [263:0] r, input logic [263:0] s);
    encode_int(r);
    r_val = int_buf;
    encode_int(s);
    s_val = int_buf;
    build_der();
  endtask

  // queue sig_buf as byte words, final mark on the last one
  task automatic send_sig();
    dersig_word_t w;
    foreach (sig_buf[i]) begin
      w.sig_byte   = sig_buf[i];
      w.final_byte = (i == sig_buf.size() - 1);
      pending_bytes.push_back(w);
    end
    n_sigs_sent++;
  endtask

  // ---------------------------------------------------------------
  // driver: offers pending words, idles at random
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      // keep offering during the output hold-off so the block backs up
      if (pending_bytes.size() != 0 &&
          (calm || hold_left > 0 || $urandom_range(99) >= 27)) begin
        next_word = pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_word.sig_byte;
        in_tlast  <= next_word.final_byte;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // receiver: random ready, one long hold-off counted here
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_used && acc_cnt >= HOLD_AT) begin
      hold_used  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 27);
    end
  end

  // ---------------------------------------------------------------
  // monitor: predict on accepted input, check accepted verdicts
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_word(in_tdata, in_tlast);
        acc_cnt <= acc_cnt + 1;
      end
      if (in_tvalid && !in_tready) n_in_stalls++;
      if (out_tvalid && !out_tready) n_out_holds++;
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict word with none expected, expected none, got %h",
                   $time, out_tdata);
          n_errors++;
        end else begin
          case (verdict_q[0])
            VERDICT_INVALID:   n_invalid++;
            VERDICT_CANONICAL: n_canon++;
            default:           n_full++;
          endcase
          // verdict in the low bits, the rest of the byte must be zero
          if (out_tdata !== {6'b0, verdict_q[0]}) begin
            $display("%0t: verdict mismatch, expected %h, got %h",
                     $time, {6'b0, verdict_q[0]}, out_tdata);
            n_errors++;
          end
          void'(verdict_q.pop_front());
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
               $time, cycle_cnt, verdict_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------
  initial begin
    int kind;
    int mut;
    int k;
    int j;
    int n_rand_sigs;
    int n_rand_bytes;

    clear_predictor();

    // directed: extremes of length and value, each malformed shape
    build_pair(264'd1, 264'd1);                          // shortest legal
    send_sig();
    build_pair(264'd1, {8'h00, HALF_G});                  // s exactly half order
    send_sig();
    build_pair(264'd1, {8'h00, HALF_G} + 1);              // s just above half
    send_sig();
    build_pair({8'h00, ORDER_G} - 1, {8'h00, ORDER_G} - 1); // longest legal, high s
    send_sig();
    build_pair({8'h00, ORDER_G}, 264'd1);                 // r equal to order
    send_sig();
    build_pair(264'd1, {8'h00, ORDER_G});                 // s equal to order
    send_sig();
    build_pair(264'h80, 264'd1);                          // needed zero pad on r
    send_sig();
    build_pair(264'd0, 264'd5);                           // zero r
    send_sig();
    build_pair(264'd5, 264'd0);                           // zero s
    send_sig();
    // unneeded zero pad on r
    encode_int(264'd1);
    int_buf.push_front(8'h00);
    r_val = int_buf;
    encode_int(264'd1);
    s_val = int_buf;
    build_der();
    send_sig();
    // negative r
    encode_int(264'h80);
    void'(int_buf.pop_front());
    r_val = int_buf;
    encode_int(264'd3);
    s_val = int_buf;
    build_der();
    send_sig();
    build_pair(264'd1, 264'd1);                           // wrong sequence tag
    sig_buf[0] = 8'h31;
    send_sig();
    build_pair(264'd1, 264'd1);                           // length byte off by one
    sig_buf[1] = sig_buf[1] + 8'd1;
    send_sig();
    build_pair(264'd1, 264'd1);                           // wrong r tag
    sig_buf[2] = 8'h03;
    send_sig();
    build_pair(264'd1, 264'd1);                           // wrong s tag
    sig_buf[5] = 8'h03;
    send_sig();
    build_pair(264'd1, 264'd1);                           // zero r length
    sig_buf[3] = 8'd0;
    send_sig();
    build_pair(264'd1, 264'd1);                           // r length of 34
    sig_buf[3] = 8'd34;
    send_sig();
    build_pair(264'd1, 264'd1);                           // trailing byte
    sig_buf.push_back(8'h00);
    sig_buf[1] = sig_buf[1] + 8'd1;
    send_sig();
    build_pair(264'd1, 264'd1);                           // final mark too early
    repeat (3) void'(sig_buf.pop_back());
    send_sig();
    sig_buf.delete();                                    // final mark on the first byte
    sig_buf.push_back(TAG_SEQUENCE);
    send_sig();
    build_pair({8'h00, ORDER_G} - 1, {8'h00, ORDER_G} - 1); // overlong, counter saturates
    repeat (3) sig_buf.push_back(8'($urandom()));
    send_sig();

    // random: half well-formed with random values, mixed with broken ones and noise
    n_rand_sigs  = 0;
    n_rand_bytes = 0;
    while (n_rand_sigs < 3 || n_rand_bytes < 100) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        sig_buf.delete();
        repeat ($urandom_range(1, 90)) sig_buf.push_back(8'($urandom()));
        if ($urandom_range(1)) sig_buf[0] = TAG_SEQUENCE;
      end else begin
        rand_value();
        r_val = int_buf;
        rand_value();
        s_val = int_buf;
        mut = (kind < 60) ? -1 : $urandom_range(11);
        if (mut == 9) begin
          if ($urandom_range(1)) r_val.push_front(8'h00);
          else s_val.push_front(8'h00);
        end
        build_der();
        case (mut)
          0: sig_buf[0] = sig_buf[0] ^ 8'($urandom_range(1, 255));
          1: sig_buf[1] = sig_buf[1] + 8'($urandom_range(1, 255));
          2: sig_buf[2] = sig_buf[2] ^ 8'($urandom_range(1, 255));
          3: sig_buf[4 + r_val.size()] = sig_buf[4 + r_val.size()] ^
                                         8'($urandom_range(1, 255));
          4: sig_buf[3] = $urandom_range(1) ? 8'd0 : 8'($urandom_range(34, 255));
          5: sig_buf[5 + r_val.size()] = 8'($urandom_range(255));
          6: repeat ($urandom_range(1, sig_buf.size() - 1)) void'(sig_buf.pop_back());
          7: begin
            k = $urandom_range(1, 3);
            repeat (k) sig_buf.push_back(8'($urandom()));
            if ($urandom_range(1)) sig_buf[1] = sig_buf[1] + 8'(k);
          end
          8: begin
            j = $urandom_range(sig_buf.size() - 1);
            sig_buf[j] = sig_buf[j] ^ (8'h01 << $urandom_range(7));
          end
          10: begin
            if ($urandom_range(1)) sig_buf[4] = sig_buf[4] | SIGN_BIT;
            else sig_buf[6 + r_val.size()] = sig_buf[6 + r_val.size()] | SIGN_BIT;
          end
          11: begin
            repeat ($urandom_range(1, 60)) sig_buf.push_back(8'($urandom()));
            sig_buf[1] = 8'(sig_buf.size() - 2);
          end
          default: ;
        endcase
      end
      n_rand_bytes += sig_buf.size();
      n_rand_sigs++;
      send_sig();
    end

    // reset held from the start, released once
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // everything driven and accepted, then every verdict back
    while (pending_bytes.size() != 0 || in_tvalid) @(negedge clk);
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d signatures in %0d bytes: %0d invalid, %0d canonical only,",
             n_sigs_sent, acc_cnt, n_invalid, n_canon);
    $display("%0d fully canonical; input stalled %0d cycles, verdicts held off %0d cycles",
             n_full, n_in_stalls, n_out_holds);
    $display("%0d errors", n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/dersig_pkg.sv
src/dersig_in_stage.sv
src/dersig_parse.sv
src/der_ecdsa_signature_canonicality_top.sv
sim/der_ecdsa_signature_canonicality_top_tb.sv
